// ===== rtl/esc_pkg.sv =====
// esc_pkg: shared types, constants and the month-length table for the
// epoch seconds to calendar block. No dependencies.
`timescale 1ns / 1ps

package esc_pkg;

    // constant division by reciprocal multiply: q = (x * RECIP) >> shift,
    // exact over the operand ranges seen here
    localparam int DIV_STAGES = 5;
    localparam logic [25:0] RECIP_DAY  = 26'd50903317;  // 2^35 / 675, on seconds >> 7
    localparam logic [16:0] RECIP_WEEK = 17'd74899;     // 2^19 / 7
    localparam logic [15:0] RECIP_MIN  = 16'd34953;     // 2^19 / 15, on seconds >> 2
    localparam logic [9:0]  RECIP_HOUR = 10'd547;       // 2^13 / 15, on minutes >> 2

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [5:0]  MINS_PER_HOUR = 6'd60;
    localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;

    localparam logic [15:0] WEEKDAY_BIAS = 16'd4;     // day zero was a Thursday
    localparam logic [7:0] EPOCH_YEAR_OFFSET = 8'd70;  // 1970 - 1900
    localparam logic [7:0] CENTURY_NO_LEAP = 8'd200;   // 2100 - 1900
    localparam logic [8:0] DAYS_COMMON = 9'd365;
    localparam logic [8:0] DAYS_LEAP = 9'd366;
    localparam logic [3:0] MONTH_LAST = 4'd11;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_CAL,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        CAL_IDLE,
        CAL_YEAR,
        CAL_MONTH
    } cal_phase_t;

    typedef struct packed {
        logic div_load;
        logic cal_start;
    } esc_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic cal_busy;
    } esc_status_t;

    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        begin
            case (mon) inside
                4'd1:                    len = leap ? 5'd29 : 5'd28;
                4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
                default:                 len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

// ===== rtl/esc_div.sv =====
// esc_div: staged constant divisions by reciprocal multiply, giving
// day count, time of day and weekday. Depends on esc_pkg.
`timescale 1ns / 1ps

module esc_div
    import esc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic [31:0] secs,
    output logic        busy,
    output logic [15:0] days,
    output logic [5:0]  second,
    output logic [5:0]  minute,
    output logic [4:0]  hour,
    output logic [2:0]  weekday
);

    logic [DIV_STAGES-1:0] stage_reg, stage_next;
    logic [31:0] secs_reg;
    logic [15:0] days_reg;
    logic [15:0] wbias_reg;
    logic [16:0] tod_reg;
    logic [10:0] mins_reg;
    logic [2:0]  wq_reg;
    logic [5:0]  second_reg;
    logic [5:0]  minute_reg;
    logic [4:0]  hour_reg;
    logic [2:0]  weekday_reg;
    logic [50:0] prod_day;
    logic [16:0] day_secs;
    logic [29:0] prod_min;
    logic [21:0] prod_week;
    logic [17:0] prod_hour;

    // stage 0: days; 1: time of day, weekday bias; 2: minutes, week count;
    // 3: second, hour, weekday; 4: minute
    assign prod_day  = 51'(secs_reg[31:7]) * 51'(RECIP_DAY);
    assign day_secs  = 17'(days_reg) * SECS_PER_DAY;          // low bits only
    assign prod_min  = 30'(tod_reg[16:2]) * 30'(RECIP_MIN);
    assign prod_week = 22'(wbias_reg) * 22'(RECIP_WEEK);      // quotient mod 8 is enough
    assign prod_hour = 18'(mins_reg[10:2]) * 18'(RECIP_HOUR);

    always_comb
    begin
        if (load)
            stage_next = {{(DIV_STAGES-1){1'b0}}, 1'b1};
        else
            stage_next = {stage_reg[DIV_STAGES-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            secs_reg <= secs;
        end
        if (stage_reg[0])
        begin
            days_reg <= prod_day[50:35];
        end
        if (stage_reg[1])
        begin
            tod_reg   <= secs_reg[16:0] - day_secs;
            wbias_reg <= days_reg + WEEKDAY_BIAS;
        end
        if (stage_reg[2])
        begin
            mins_reg <= prod_min[29:19];
            wq_reg   <= prod_week[21:19];
        end
        if (stage_reg[3])
        begin
            second_reg  <= tod_reg[5:0] - mins_reg[5:0] * SECS_PER_MIN;
            hour_reg    <= prod_hour[17:13];
            weekday_reg <= wbias_reg[2:0] - wq_reg * DAYS_PER_WEEK;
        end
        if (stage_reg[4])
        begin
            minute_reg <= mins_reg[5:0] - 6'(hour_reg) * MINS_PER_HOUR;
        end
    end

    assign busy    = (stage_reg != '0);
    assign days    = days_reg;
    assign second  = second_reg;
    assign minute  = minute_reg;
    assign hour    = hour_reg;
    assign weekday = weekday_reg;

endmodule

// ===== rtl/esc_cal.sv =====
// esc_cal: year walk then month walk over the day count, one step a cycle.
// Depends on esc_pkg.
`timescale 1ns / 1ps

module esc_cal
    import esc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] days_in,
    output logic        busy,
    output logic [8:0]  day_of_year,
    output logic [7:0]  year_offset,
    output logic [3:0]  month_index,
    output logic [4:0]  day_of_month
);

    cal_phase_t  phase_reg, phase_next;
    logic [15:0] days_reg, days_next;
    logic [7:0]  year_reg, year_next;
    logic [3:0]  mon_reg, mon_next;
    logic        leap_reg, leap_next;
    logic [8:0]  doy_reg, doy_next;
    logic        leap_now;
    logic [8:0]  ylen;
    logic [4:0]  mlen;

    // Gregorian rule over 1970..2106: only 2100 breaks the every-fourth-year rule
    assign leap_now = (year_reg[1:0] == 2'b00) && (year_reg != CENTURY_NO_LEAP);
    assign ylen     = leap_now ? DAYS_LEAP : DAYS_COMMON;
    assign mlen     = month_len(mon_reg, leap_reg);

    always_comb
    begin
        phase_next = phase_reg;
        days_next  = days_reg;
        year_next  = year_reg;
        mon_next   = mon_reg;
        leap_next  = leap_reg;
        doy_next   = doy_reg;
        unique case (phase_reg)
            CAL_IDLE:
            begin
                if (start)
                begin
                    phase_next = CAL_YEAR;
                    days_next  = days_in;
                    year_next  = EPOCH_YEAR_OFFSET;
                end
            end
            CAL_YEAR:
            begin
                if (days_reg >= {7'd0, ylen})
                begin
                    days_next = days_reg - {7'd0, ylen};
                    year_next = year_reg + 8'd1;
                end
                else
                begin
                    phase_next = CAL_MONTH;
                    leap_next  = leap_now;
                    doy_next   = days_reg[8:0];
                    mon_next   = '0;
                end
            end
            CAL_MONTH:
            begin
                if ((mon_reg < MONTH_LAST) && (days_reg >= {11'd0, mlen}))
                begin
                    days_next = days_reg - {11'd0, mlen};
                    mon_next  = mon_reg + 4'd1;
                end
                else
                begin
                    phase_next = CAL_IDLE;
                end
            end
            default:
            begin
                phase_next = CAL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= CAL_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        days_reg <= days_next;
        year_reg <= year_next;
        mon_reg  <= mon_next;
        leap_reg <= leap_next;
        doy_reg  <= doy_next;
    end

    assign busy         = (phase_reg != CAL_IDLE);
    assign day_of_year  = doy_reg;
    assign year_offset  = year_reg;
    assign month_index  = mon_reg;
    assign day_of_month = days_reg[4:0] + 5'd1;

endmodule

// ===== rtl/esc_dp.sv =====
// esc_dp: datapath. Constant-division unit for day count, time of day and
// weekday, and the calendar walker. Depends on esc_pkg, esc_div, esc_cal.
`timescale 1ns / 1ps

module esc_dp
    import esc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  esc_cmd_t    cmd,
    output esc_status_t status,
    input  logic [31:0] epoch_seconds,
    output logic [5:0]  second,
    output logic [5:0]  minute,
    output logic [4:0]  hour,
    output logic [2:0]  weekday,
    output logic [8:0]  day_of_year,
    output logic [7:0]  year_offset,
    output logic [3:0]  month_index,
    output logic [4:0]  day_of_month
);

    logic        div_busy;
    logic        cal_busy;
    logic [15:0] days;

    esc_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (cmd.div_load),
        .secs    (epoch_seconds),
        .busy    (div_busy),
        .days    (days),
        .second  (second),
        .minute  (minute),
        .hour    (hour),
        .weekday (weekday)
    );

    esc_cal u_cal (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (cmd.cal_start),
        .days_in      (days),
        .busy         (cal_busy),
        .day_of_year  (day_of_year),
        .year_offset  (year_offset),
        .month_index  (month_index),
        .day_of_month (day_of_month)
    );

    assign status.div_busy = div_busy;
    assign status.cal_busy = cal_busy;

endmodule

// ===== rtl/esc_ctrl.sv =====
// esc_ctrl: sequencing state machine for the division unit and calendar walk.
// Depends on esc_pkg.
`timescale 1ns / 1ps

module esc_ctrl
    import esc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  esc_status_t status,
    output esc_cmd_t    cmd,
    output logic        busy,
    output logic        done
);

    ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_DIV;
            ST_DIV:  if (!status.div_busy) state_next = ST_CAL;
            ST_CAL:  if (!status.cal_busy) state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.div_load  = 1'b0;
        cmd.cal_start = 1'b0;
        busy          = 1'b1;
        done          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy         = 1'b0;
                cmd.div_load = start;
            end
            ST_DIV:
            begin
                cmd.cal_start = !status.div_busy;
            end
            ST_CAL:
            begin
                busy = 1'b1;
            end
            ST_OUT:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    // results go out only once both units have finished
    a_done_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!status.div_busy && !status.cal_busy))
        else $error("result strobe while a unit is still running");

    // an accepted beat takes the block busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // one strobe per beat
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    // the calendar walk starts only once the day count is final
    a_cal_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cal_start |-> !status.div_busy)
        else $error("calendar walk started before the day count");

    // the division unit is loaded only from idle
    a_load_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_load |-> !busy)
        else $error("division unit loaded while a beat is in flight");
`endif

endmodule

// ===== rtl/epoch_seconds_to_calendar.sv =====
// epoch_seconds_to_calendar: top level, UTC broken-down time from epoch seconds.
// Depends on esc_pkg, esc_ctrl, esc_dp (and through it esc_div, esc_cal).
`timescale 1ns / 1ps

//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-----------------------------
//  input    | epoch_seconds                           | beat taken when start && !busy
//  result   | second minute hour weekday day_of_year  | one beat per input, valid
//           | year_offset month_index day_of_month    | for the single cycle of done
//
//  One beat at a time. From the accepting edge to the edge that takes the result,
//  the block runs the reciprocal-multiply division, a handoff to the calendar
//  walker, the year walk (one year per cycle, up to 136 steps) and month walk (up
//  to 11 steps) with their entry and exit, and the done cycle. busy drops the
//  cycle after done. Reset (rst_n low, asynchronous) returns the controller and
//  both units to idle. The receiver cannot stall: done is a one-cycle strobe,
//  and the result ports are valid only during that cycle.

module epoch_seconds_to_calendar
    import esc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] epoch_seconds,
    output logic        busy,
    output logic        done,
    output logic [5:0]  second,
    output logic [5:0]  minute,
    output logic [4:0]  hour,
    output logic [2:0]  weekday,
    output logic [8:0]  day_of_year,
    output logic [7:0]  year_offset,
    output logic [3:0]  month_index,
    output logic [4:0]  day_of_month
);

    // command and status between sequencer and datapath
    esc_cmd_t    cmd;
    esc_status_t status;

    esc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // datapath: constant divisions for the day count, time of day and weekday;
    // calendar walker for year, day of year, month and day of month
    esc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .epoch_seconds (epoch_seconds),
        .second        (second),
        .minute        (minute),
        .hour          (hour),
        .weekday       (weekday),
        .day_of_year   (day_of_year),
        .year_offset   (year_offset),
        .month_index   (month_index),
        .day_of_month  (day_of_month)
    );

endmodule

// ===== tb/tb.sv =====
// tb: self-checking bench for epoch_seconds_to_calendar (UTC broken-down time).
// Needs only rtl/esc_pkg.sv and the block's RTL; the calendar math is predicted
// here.
`timescale 1ns / 1ps

module tb;

    // ---------------------------------------------------------------------
    // Clock, reset, DUT ports
    // ---------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] epoch_seconds = '0;
    logic        busy;
    logic        done;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [2:0]  weekday;
    logic [8:0]  day_of_year;
    logic [7:0]  year_offset;
    logic [3:0]  month_index;
    logic [4:0]  day_of_month;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    epoch_seconds_to_calendar uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .epoch_seconds(epoch_seconds),
        .busy         (busy),
        .done         (done),
        .second       (second),
        .minute       (minute),
        .hour         (hour),
        .weekday      (weekday),
        .day_of_year  (day_of_year),
        .year_offset  (year_offset),
        .month_index  (month_index),
        .day_of_month (day_of_month)
    );

    // ---------------------------------------------------------------------
    // Calendar constants
    // ---------------------------------------------------------------------
    localparam int unsigned SECS_IN_DAY = 86400;
    localparam int unsigned FIRST_YEAR  = 1970;
    localparam int unsigned LAST_YEAR   = 2106;   // 32-bit counter runs out in Feb 2106
    localparam int unsigned TM_YEAR_REF = 1900;
    localparam int unsigned YEAR_WALK_CAP = 140;
    localparam int unsigned THURSDAY    = 4;      // weekday of day zero

    // month indexes that differ from 31 days, plus the last one
    localparam int unsigned MON_FEB = 1;
    localparam int unsigned MON_APR = 3;
    localparam int unsigned MON_JUN = 5;
    localparam int unsigned MON_SEP = 8;
    localparam int unsigned MON_NOV = 10;
    localparam int unsigned MON_DEC = 11;

    localparam int LATENCY_MARGIN = 200;      // above the worst-case time per beat
    localparam int MAX_REPORTS    = 10;

    // one broken-down time, tagged with the input it came from
    typedef struct {
        logic [31:0] seconds;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [2:0]  weekday;
        logic [8:0]  day_of_year;
        logic [7:0]  year_offset;
        logic [3:0]  month_index;
        logic [4:0]  day_of_month;
    } utc_fields_t;

    // stimulus beat; drain_first holds the beat back until every result is in
    typedef struct {
        logic [31:0] seconds;
        bit          drain_first;
    } time_beat_t;

    time_beat_t  pending_times[$];
    utc_fields_t expected_utc[$];

    int mismatches = 0;
    int directed_count = 0;
    int results_seen = 0;
    int leap_days_seen = 0;
    int late_years_seen = 0;

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------
    function automatic bit gregorian_leap(input int unsigned yr);
        return (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
    endfunction

    function automatic utc_fields_t utc_of_epoch(input logic [31:0] secs);
        utc_fields_t r;
        int unsigned tod;
        int unsigned days;
        int unsigned yr;
        int unsigned ylen;
        int unsigned walked;
        int unsigned mon;
        int unsigned mlen;
        tod  = secs % SECS_IN_DAY;
        days = secs / SECS_IN_DAY;
        r.seconds = secs;
        r.second  = 6'(tod % 60);
        r.minute  = 6'((tod / 60) % 60);
        r.hour    = 5'(tod / 3600);
        r.weekday = 3'((days + THURSDAY) % 7);

        // strip whole years
        yr = FIRST_YEAR;
        walked = 0;
        ylen = gregorian_leap(yr) ? 366 : 365;
        while (days >= ylen && walked < YEAR_WALK_CAP)
        begin
            days -= ylen;
            yr++;
            walked++;
            ylen = gregorian_leap(yr) ? 366 : 365;
        end
        r.day_of_year = 9'(days);

        // strip whole months; December takes whatever is left
        mon = 0;
        while (mon < MON_DEC)
        begin
            case (mon) inside
                MON_FEB:                           mlen = (ylen == 366) ? 29 : 28;
                MON_APR, MON_JUN, MON_SEP, MON_NOV: mlen = 30;
                default:                           mlen = 31;
            endcase
            if (days < mlen)
                break;
            days -= mlen;
            mon++;
        end
        r.year_offset  = 8'(yr - TM_YEAR_REF);
        r.month_index  = 4'(mon);
        r.day_of_month = 5'(days + 1);
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Driver: bursts of beats with random gaps; a beat flagged drain_first
    // waits until the block has nothing in flight.
    // ---------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;
    int in_flight = 0;    // driver's own count, so it never races the monitor
    bit took;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            epoch_seconds <= '0;
            burst_left = 0;
            gap_left = 0;
            in_flight = 0;
        end
        else
        begin
            took = start && !busy;
            if (took)
                expected_utc.push_back(utc_of_epoch(epoch_seconds));
            in_flight = in_flight + int'(took) - int'(done === 1'b1);

            if (start && !took)
                ;   // beat still offered, block busy: hold everything
            else if (gap_left != 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_times.size() == 0
                     || (pending_times[0].drain_first && in_flight != 0))
                start <= 1'b0;
            else
            begin
                start <= 1'b1;
                epoch_seconds <= pending_times[0].seconds;
                pending_times.pop_front();
                // mostly short bursts, sometimes long unbroken runs
                if (burst_left == 0)
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 8);
                burst_left--;
                // gaps up to past the latency so idle time lands on every phase
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 12)
                                                           : $urandom_range(13, 200);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: done is a one-cycle strobe, sampled at the edge that ends it
    // ---------------------------------------------------------------------
    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got, input logic [31:0] secs);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("tb: mismatch on %s for t=%0d: expected %0d, got %0d",
                         what, secs, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (expected_utc.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("tb: result beat with no conversion outstanding");
            end
            else
            begin
                check_field("second", 32'(expected_utc[0].second), 32'(second),
                            expected_utc[0].seconds);
                check_field("minute", 32'(expected_utc[0].minute), 32'(minute),
                            expected_utc[0].seconds);
                check_field("hour", 32'(expected_utc[0].hour), 32'(hour),
                            expected_utc[0].seconds);
                check_field("weekday", 32'(expected_utc[0].weekday), 32'(weekday),
                            expected_utc[0].seconds);
                check_field("day_of_year", 32'(expected_utc[0].day_of_year),
                            32'(day_of_year), expected_utc[0].seconds);
                check_field("year_offset", 32'(expected_utc[0].year_offset),
                            32'(year_offset), expected_utc[0].seconds);
                check_field("month_index", 32'(expected_utc[0].month_index),
                            32'(month_index), expected_utc[0].seconds);
                check_field("day_of_month", 32'(expected_utc[0].day_of_month),
                            32'(day_of_month), expected_utc[0].seconds);
                if (expected_utc[0].month_index == MON_FEB
                    && expected_utc[0].day_of_month == 29)
                    leap_days_seen++;
                if (expected_utc[0].year_offset >= 200)
                    late_years_seen++;
                results_seen++;
                expected_utc.pop_front();
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------------
    int unsigned year_first_day [FIRST_YEAR:LAST_YEAR];

    initial
    begin
        logic [31:0] directed [$];
        longint      t;
        int unsigned yr;
        int unsigned day;
        int          kind;

        // directed: field extremes, year/leap edges, the 2100 exception, all-ones
        directed = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
                     32'd86400,
                     32'd31535999,    // last second of 1970
                     32'd31536000,    // first second of 1971
                     32'd68169600,    // 1972-02-29
                     32'd94694399,    // end of a leap year, day_of_year 365
                     32'd951782400,   // 2000-02-29, the 400-year rule
                     32'd978307199,   // end of 2000
                     32'h7FFFFFFF, 32'h80000000,
                     32'd4102444799,  // end of 2099
                     32'd4107456000,  // 2100-02-28
                     32'd4107542400,  // 2100-03-01, no Feb 29 in 2100
                     32'd4133980799,  // end of 2100, only 365 days
                     32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFE, 32'hFFFFFFFF};
        foreach (directed[i])
            pending_times.push_back('{directed[i], i == 15});
        directed_count = directed.size();

        year_first_day[FIRST_YEAR] = 0;
        for (int y = FIRST_YEAR + 1; y <= LAST_YEAR; y++)
            year_first_day[y] = year_first_day[y-1] + (gregorian_leap(y - 1) ? 366 : 365);

        // random: raw words plus times steered onto year, leap and month edges
        for (int i = 0; i < 727; i++)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 8)
                t = $urandom;
            else if (kind < 12)
            begin
                // within a day of a New Year's midnight
                yr = $urandom_range(FIRST_YEAR + 1, LAST_YEAR);
                t = longint'(year_first_day[yr]) * SECS_IN_DAY
                    + longint'($urandom_range(0, 2 * SECS_IN_DAY)) - SECS_IN_DAY;
            end
            else if (kind < 15)
            begin
                // Feb 28 through Mar 1 (leap) or Mar 2 (common) of any year
                yr = $urandom_range(FIRST_YEAR, LAST_YEAR - 1);
                day = year_first_day[yr] + $urandom_range(58, 60);
                t = longint'(day) * SECS_IN_DAY + $urandom_range(0, SECS_IN_DAY - 1);
            end
            else
            begin
                // any day of a year, time of day pushed toward midnight
                yr = $urandom_range(FIRST_YEAR, LAST_YEAR - 1);
                day = year_first_day[yr] + $urandom_range(0, 365);
                t = longint'(day) * SECS_IN_DAY
                    + (($urandom_range(0, 1) == 0) ? $urandom_range(0, 3)
                                                    : SECS_IN_DAY - 1 - $urandom_range(0, 3));
            end
            if (t < 0)
                t = 0;
            if (t > 64'hFFFFFFFF)
                t = 64'hFFFFFFFF;
            pending_times.push_back('{t[31:0], $urandom_range(0, 39) == 0});
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the last beat to go in and its result to come out
        @(negedge clk);
        while (pending_times.size() != 0 || expected_utc.size() != 0 || start)
            @(negedge clk);
        repeat (LATENCY_MARGIN) @(negedge clk);

        $display("tb: %0d conversions checked (%0d directed, rest random over 1970-2106)",
                 results_seen, directed_count);
        $display("tb: %0d landed on Feb 29, %0d in 2100 or later; %0d mismatches",
                 leap_days_seen, late_years_seen, mismatches);
        if (mismatches == 0 && expected_utc.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // watchdog: several times the slowest correct run
    initial
    begin
        #2000000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/esc_pkg.sv
rtl/esc_div.sv
rtl/esc_cal.sv
rtl/esc_dp.sv
rtl/esc_ctrl.sv
rtl/epoch_seconds_to_calendar.sv
tb/tb.sv
